// File: design/rgbgd_pkg.sv
`timescale 1ns / 1ps
// shared constants and types of the rgb565 gray box downscaler
package rgbgd_pkg;

    localparam int OUT_SIZE = 96;
    localparam int CNT_W    = $clog2(OUT_SIZE + 1);
    localparam int ADDR_W   = $clog2(OUT_SIZE);
    localparam int OUT_W    = 7;
    localparam int GRAY_W   = 7;
    localparam int SUM_W    = 18;
    localparam int AREA_W   = 11;
    localparam int FW_W     = 12;
    localparam int WIN_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int DIV_STEP_W = $clog2(SUM_W + 1);

    localparam logic [CNT_W-1:0] GRID_LIMIT = CNT_W'(OUT_SIZE);
    localparam logic [CNT_W-1:0] GRID_LAST  = CNT_W'(OUT_SIZE - 1);
    localparam logic [WIN_W-1:0] MAX_WIN    = WIN_W'(42);

    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST   = FW_W'(640);
    localparam logic [WIN_W-1:0] WINDOW_WIDTH_RST  = WIN_W'(6);
    localparam logic [WIN_W-1:0] WINDOW_HEIGHT_RST = WIN_W'(5);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = CFG_IDX_W'(2);

    typedef struct packed {
        logic              in_grid;
        logic              first_px;
        logic              emit;
        logic              grid_end;
        logic [ADDR_W-1:0] addr;
        logic [OUT_W-1:0]  col;
        logic [OUT_W-1:0]  row;
        logic [AREA_W-1:0] area;
    } pos_info_t;

endpackage

// File: design/rgbgd_ram.sv
`timescale 1ns / 1ps
// generic single-port-write, registered-read ram
module rgbgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/rgbgd_div.sv
`timescale 1ns / 1ps
// bit-serial restoring divider for the window mean
module rgbgd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rgbgd_pkg::SUM_W-1:0]  dividend,
    input  logic [rgbgd_pkg::AREA_W-1:0] divisor,
    output logic                        busy,
    output logic [rgbgd_pkg::SUM_W-1:0]  quotient
);
    import rgbgd_pkg::*;

    logic                  busy_reg, busy_next;
    logic [DIV_STEP_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]      quo_reg, quo_next;
    logic [AREA_W-1:0]     rem_reg, rem_next;
    logic [AREA_W-1:0]     dvs_reg, dvs_next;
    logic [AREA_W:0]       shifted;
    logic [AREA_W:0]       diff;
    logic                  fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[SUM_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        fits      = shifted >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_STEP_W'(SUM_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[AREA_W-1:0] : shifted[AREA_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], fits};
            cnt_next = cnt_reg - DIV_STEP_W'(1);
            if (cnt_reg == DIV_STEP_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: design/rgbgd_pos.sv
`timescale 1ns / 1ps
// configuration registers and raster position counters
module rgbgd_pos (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rgbgd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbgd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            step,
    input  logic                            first_of_frame,
    output rgbgd_pkg::pos_info_t            info
);
    import rgbgd_pkg::*;

    logic [FW_W-1:0]  frame_width_reg;
    logic [WIN_W-1:0] window_width_reg;
    logic [WIN_W-1:0] window_height_reg;

    logic [FW_W-1:0]  pcol_reg, pcol_next;
    logic [WIN_W-1:0] riw_reg, riw_next;
    logic [CNT_W-1:0] wrow_reg, wrow_next;
    logic [WIN_W-1:0] ciw_reg, ciw_next;
    logic [CNT_W-1:0] wcol_reg, wcol_next;

    logic [FW_W-1:0]    pcol, pcol_inc;
    logic [WIN_W-1:0]   riw, ciw, ww_e, wh_e;
    logic [CNT_W-1:0]   wrow, wcol;
    logic               last_col, last_row, col_ok, row_ok;
    logic [2*WIN_W-1:0] area_full;

    always_comb
    begin
        // effective window sizes
        if (window_width_reg == '0)
            ww_e = WIN_W'(1);
        else if (window_width_reg > MAX_WIN)
            ww_e = MAX_WIN;
        else
            ww_e = window_width_reg;
        if (window_height_reg == '0)
            wh_e = WIN_W'(1);
        else if (window_height_reg > MAX_WIN)
            wh_e = MAX_WIN;
        else
            wh_e = window_height_reg;

        pcol = first_of_frame ? '0 : pcol_reg;
        riw  = first_of_frame ? '0 : riw_reg;
        wrow = first_of_frame ? '0 : wrow_reg;
        ciw  = first_of_frame ? '0 : ciw_reg;
        wcol = first_of_frame ? '0 : wcol_reg;

        last_col  = ({1'b0, ciw} + (WIN_W+1)'(1)) >= {1'b0, ww_e};
        last_row  = ({1'b0, riw} + (WIN_W+1)'(1)) >= {1'b0, wh_e};
        col_ok    = wcol < GRID_LIMIT;
        row_ok    = wrow < GRID_LIMIT;
        area_full = {{WIN_W{1'b0}}, ww_e} * {{WIN_W{1'b0}}, wh_e};

        info.in_grid  = col_ok && row_ok;
        info.first_px = (riw == '0) && (ciw == '0);
        info.emit     = col_ok && row_ok && last_col && last_row;
        info.grid_end = (wrow == GRID_LAST) && (wcol == GRID_LAST);
        info.addr     = wcol[ADDR_W-1:0];
        info.col      = OUT_W'(wcol);
        info.row      = OUT_W'(wrow);
        info.area     = area_full[AREA_W-1:0];

        // advance position
        riw_next  = riw;
        wrow_next = wrow;
        if (last_col)
        begin
            ciw_next  = '0;
            wcol_next = col_ok ? wcol + CNT_W'(1) : wcol;
        end
        else
        begin
            ciw_next  = ciw + WIN_W'(1);
            wcol_next = wcol;
        end
        pcol_inc  = pcol + FW_W'(1);
        pcol_next = pcol_inc;
        if (pcol_inc == frame_width_reg)
        begin
            pcol_next = '0;
            ciw_next  = '0;
            wcol_next = '0;
            if (last_row)
            begin
                riw_next  = '0;
                wrow_next = row_ok ? wrow + CNT_W'(1) : wrow;
            end
            else
            begin
                riw_next = riw + WIN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= FRAME_WIDTH_RST;
            window_width_reg  <= WINDOW_WIDTH_RST;
            window_height_reg <= WINDOW_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[FW_W-1:0];
                REG_WINDOW_WIDTH:  window_width_reg  <= cfg_data[WIN_W-1:0];
                REG_WINDOW_HEIGHT: window_height_reg <= cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcol_reg <= '0;
            riw_reg  <= '0;
            wrow_reg <= '0;
            ciw_reg  <= '0;
            wcol_reg <= '0;
        end
        else if (step)
        begin
            pcol_reg <= pcol_next;
            riw_reg  <= riw_next;
            wrow_reg <= wrow_next;
            ciw_reg  <= ciw_next;
            wcol_reg <= wcol_next;
        end
    end

endmodule

// File: design/rgb565_gray_box_downscaler.sv
`timescale 1ns / 1ps
// top level of the rgb565 gray box downscaler
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | input     | in_valid / in_ready  | pixel, first_of_frame
//  out     | output    | out_valid / out_ready| gray_value, out_col, out_row, frame_done
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  a pixel that closes no window: column sum ram read as it is taken, then write back in S_UPD
//  a pixel that closes a window then goes to S_DIV for the 18-step bit-serial divider and a free output register
//  one request in flight at a time; in_ready is high only while the datapath is free
//  a finished result sits in the output register while the next request is taken
//  cfg_ready is always high; column sum ram has no clearing pass after reset
module rgb565_gray_box_downscaler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [15:0]                     pixel,
    input  logic                            first_of_frame,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rgbgd_pkg::GRAY_W-1:0]     gray_value,
    output logic [rgbgd_pkg::OUT_W-1:0]      out_col,
    output logic [rgbgd_pkg::OUT_W-1:0]      out_row,
    output logic                            frame_done,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rgbgd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbgd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rgbgd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_UPD  = 3'b010,
        S_DIV  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic              accept;
    logic              load_out;
    pos_info_t         info;
    pos_info_t         info_reg;
    logic [GRAY_W-1:0] gray, gray_reg;
    logic [SUM_W-1:0]  rd_sum, new_sum;
    logic              div_start, div_busy;
    logic [SUM_W-1:0]  quotient;

    logic              out_valid_reg;
    logic [GRAY_W-1:0] gray_value_reg;
    logic [OUT_W-1:0]  out_col_reg, out_row_reg;
    logic              frame_done_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign gray = GRAY_W'(pixel[15:11]) + GRAY_W'(pixel[10:5]) + GRAY_W'(pixel[4:0]);

    rgbgd_pos u_pos (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .step           (accept),
        .first_of_frame (first_of_frame),
        .info           (info)
    );

    rgbgd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (OUT_SIZE)
    ) u_sums (
        .clk   (clk),
        .we    ((state_reg == S_UPD) && info_reg.in_grid),
        .waddr (info_reg.addr),
        .wdata (new_sum),
        .re    (accept),
        .raddr (info.addr),
        .rdata (rd_sum)
    );

    assign new_sum   = info_reg.first_px ? SUM_W'(gray_reg) : rd_sum + SUM_W'(gray_reg);
    assign div_start = (state_reg == S_UPD) && info_reg.emit;

    rgbgd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (new_sum),
        .divisor  (info_reg.area),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign load_out = (state_reg == S_DIV) && !div_busy && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                state_next = info_reg.emit ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            info_reg <= info;
            gray_reg <= gray;
        end
        if (load_out)
        begin
            gray_value_reg <= quotient[GRAY_W-1:0];
            out_col_reg    <= info_reg.col;
            out_row_reg    <= info_reg.row;
            frame_done_reg <= info_reg.grid_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign gray_value = gray_value_reg;
    assign out_col    = out_col_reg;
    assign out_row    = out_row_reg;
    assign frame_done = frame_done_reg;

    // a window close must start the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) && info_reg.emit |=> div_busy)
        else $error("divider not started on window close");

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request taken while datapath busy");

    // frame end flag only on the last grid cell
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |->
            (out_col == OUT_W'(OUT_SIZE - 1)) && (out_row == OUT_W'(OUT_SIZE - 1)))
        else $error("frame_done away from last grid cell");

    // a result is loaded only once the divider has finished
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !div_busy && !div_start)
        else $error("result loaded during division");

endmodule
